// File: sv/pcsp_pkg.sv
package pcsp_pkg;

	// coordinate accumulator width and result field width
	localparam int COORD_BITS = 24;
	localparam int FIELD_BITS = 24;
	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

	// input command codes
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_EOS  = 1'b1;

	// result kind codes
	localparam logic KIND_SEGMENT   = 1'b0;
	localparam logic KIND_TRACK_END = 1'b1;

	// characters that steer the token parser
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;

	typedef struct packed {
		logic                  kind;
		logic [FIELD_BITS-1:0] from_x;
		logic [FIELD_BITS-1:0] from_y;
		logic [FIELD_BITS-1:0] to_x;
		logic [FIELD_BITS-1:0] to_y;
	} pcsp_result_t;

	typedef struct packed {
		logic         valid;
		pcsp_result_t res;
	} pcsp_emit_t;

	// true for characters the parser looks at
	function automatic logic is_kept(input logic [7:0] c);
		return (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9) ||
			c == CH_BANG || c == CH_COMMA;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	// acc * 10 + d, saturating at the coordinate width
	function automatic logic [COORD_BITS-1:0] acc_digit(input logic [COORD_BITS-1:0] acc,
		input logic [3:0] d);
		logic [COORD_BITS+3:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{COORD_BITS{1'b0}}, d};
		if (v > {4'b0000, COORD_MAX}) begin
			return COORD_MAX;
		end
		return v[COORD_BITS-1:0];
	endfunction

	function automatic logic [FIELD_BITS-1:0] to_field(input logic [COORD_BITS-1:0] v);
		return FIELD_BITS'(v);
	endfunction

endpackage

// File: sv/pcsp_core.sv
module pcsp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                cmd,
	input  logic [7:0]          data_byte,
	output pcsp_pkg::pcsp_emit_t emit
);
	import pcsp_pkg::*;

	typedef enum logic [3:0] {
		TS_START,
		TS_P,
		TS_PU,
		TS_PU_X,
		TS_PU_C,
		TS_PU_Y,
		TS_PD,
		TS_PD_X,
		TS_PD_C,
		TS_PD_Y,
		TS_DEAD
	} tok_state_t;

	tok_state_t            tok_q, tok_d;
	logic [COORD_BITS-1:0] x_acc_q, x_acc_d;
	logic [COORD_BITS-1:0] y_acc_q, y_acc_d;
	logic [COORD_BITS-1:0] pen_x_q, pen_x_d;
	logic [COORD_BITS-1:0] pen_y_q, pen_y_d;
	logic                  track_q, track_d;
	logic [3:0]            digit;
	logic                  dig;

	assign dig   = is_digit(data_byte);
	assign digit = 4'(data_byte - CH_0);

	// token parser, pen tracking and result forming for the current word
	always_comb begin
		tok_d   = tok_q;
		x_acc_d = x_acc_q;
		y_acc_d = y_acc_q;
		pen_x_d = pen_x_q;
		pen_y_d = pen_y_q;
		track_d = track_q;
		emit    = '0;
		if (cmd == CMD_EOS) begin
			emit.valid      = track_q;
			emit.res.kind   = KIND_TRACK_END;
			track_d         = 1'b0;
			pen_x_d         = '0;
			pen_y_d         = '0;
			tok_d           = TS_START;
			x_acc_d         = '0;
			y_acc_d         = '0;
		end else if (data_byte == CH_SEMI) begin
			if (tok_q == TS_PU || tok_q == TS_PU_Y) begin
				emit.valid    = track_q;
				emit.res.kind = KIND_TRACK_END;
				track_d       = 1'b0;
				if (tok_q == TS_PU_Y) begin
					pen_x_d = x_acc_q;
					pen_y_d = y_acc_q;
				end
			end else if (tok_q == TS_PD_Y) begin
				emit.valid       = 1'b1;
				emit.res.kind    = KIND_SEGMENT;
				emit.res.from_x  = to_field(pen_x_q);
				emit.res.from_y  = to_field(pen_y_q);
				emit.res.to_x    = to_field(x_acc_q);
				emit.res.to_y    = to_field(y_acc_q);
				pen_x_d          = x_acc_q;
				pen_y_d          = y_acc_q;
				track_d          = 1'b1;
			end
			tok_d   = TS_START;
			x_acc_d = '0;
			y_acc_d = '0;
		end else if (is_kept(data_byte)) begin
			tok_d = TS_DEAD;
			unique case (tok_q)
				TS_START: begin
					if (data_byte == CH_P) tok_d = TS_P;
				end
				TS_P: begin
					if (data_byte == CH_U) tok_d = TS_PU;
					else if (data_byte == CH_D) tok_d = TS_PD;
				end
				TS_PU, TS_PD: begin
					if (dig) begin
						x_acc_d = COORD_BITS'(digit);
						tok_d   = (tok_q == TS_PU) ? TS_PU_X : TS_PD_X;
					end
				end
				TS_PU_X, TS_PD_X: begin
					if (dig) begin
						x_acc_d = acc_digit(x_acc_q, digit);
						tok_d   = tok_q;
					end else if (data_byte == CH_COMMA) begin
						tok_d = (tok_q == TS_PU_X) ? TS_PU_C : TS_PD_C;
					end
				end
				TS_PU_C, TS_PD_C: begin
					if (dig) begin
						y_acc_d = COORD_BITS'(digit);
						tok_d   = (tok_q == TS_PU_C) ? TS_PU_Y : TS_PD_Y;
					end
				end
				TS_PU_Y, TS_PD_Y: begin
					if (dig) begin
						y_acc_d = acc_digit(y_acc_q, digit);
						tok_d   = tok_q;
					end
				end
				default: begin
					tok_d = TS_DEAD;
				end
			endcase
		end
	end

	// parser state and pen position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= TS_START;
			x_acc_q <= '0;
			y_acc_q <= '0;
			pen_x_q <= '0;
			pen_y_q <= '0;
			track_q <= 1'b0;
		end else if (step) begin
			tok_q   <= tok_d;
			x_acc_q <= x_acc_d;
			y_acc_q <= y_acc_d;
			pen_x_q <= pen_x_d;
			pen_y_q <= pen_y_d;
			track_q <= track_d;
		end
	end

endmodule

// File: sv/pcsp_out_reg.sv
module pcsp_out_reg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  pcsp_pkg::pcsp_emit_t               emit,
	output logic                               can_load,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               kind,
	output logic [pcsp_pkg::FIELD_BITS-1:0]    from_x,
	output logic [pcsp_pkg::FIELD_BITS-1:0]    from_y,
	output logic [pcsp_pkg::FIELD_BITS-1:0]    to_x,
	output logic [pcsp_pkg::FIELD_BITS-1:0]    to_y
);
	import pcsp_pkg::*;

	logic         valid_q;
	pcsp_result_t res_q;

	// free when empty or when the held word leaves this cycle
	assign can_load = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= emit.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step && emit.valid) begin
			res_q <= emit.res;
		end
	end

	assign out_valid = valid_q;
	assign kind      = res_q.kind;
	assign from_x    = res_q.from_x;
	assign from_y    = res_q.from_y;
	assign to_x      = res_q.to_x;
	assign to_y      = res_q.to_y;

endmodule

// File: sv/plotter_command_segment_parser.sv
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     cmd, data_byte
// out      output     out_valid / out_ready   kind, from_x, from_y, to_x, to_y
//
// one word per cycle when not stalled: a word is held in the input stage, where the
// parser and pen update run, and its result (if any) lands in the output register.
// a word's result is loaded into the output register from the input stage register.
// arst_n clears the parser to start of token, the pen to (0,0) and both valid flags.
// a held result stalls the input stage only if the output is not taken that cycle.
module plotter_command_segment_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            kind,
	output logic [pcsp_pkg::FIELD_BITS-1:0] from_x,
	output logic [pcsp_pkg::FIELD_BITS-1:0] from_y,
	output logic [pcsp_pkg::FIELD_BITS-1:0] to_x,
	output logic [pcsp_pkg::FIELD_BITS-1:0] to_y
);
	import pcsp_pkg::*;

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       step;
	pcsp_emit_t emit;

	assign step     = valid_s1 && can_load;
	assign in_ready = !valid_s1 || step;

	// input stage flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			byte_s1 <= data_byte;
		end
	end

	pcsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.emit      (emit)
	);

	pcsp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.emit      (emit),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y)
	);

`ifndef SYNTHESIS
	// a track end carries no coordinates
	a_track_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_TRACK_END) |->
		(from_x == '0 && from_y == '0 && to_x == '0 && to_y == '0))
		else $error("track end with nonzero coordinates");

	// an accepted word always lands in the input stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted word lost");

	// no result appears without a word being processed
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !step) |=> !out_valid)
		else $error("result without processed word");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;

	import pcsp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int STREAM_WORDS   = 925;
	localparam int DRAIN_SPACING  = 300;
	localparam int TAIL_CYCLES    = 8;
	localparam int HOLD_CYCLES    = 120;

	localparam string KEPT_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!,";

	// parser position inside the current token
	typedef enum logic [3:0] {
		TOK_START,
		TOK_P,
		TOK_PU,
		TOK_PU_X,
		TOK_PU_COMMA,
		TOK_PU_Y,
		TOK_PD,
		TOK_PD_X,
		TOK_PD_COMMA,
		TOK_PD_Y,
		TOK_DEAD
	} tok_state_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	// one stream word, or a marker that pauses the sender until all results are back
	typedef struct {
		logic       drain;
		logic       cmd;
		logic [7:0] data;
	} stream_word_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  cmd       = CMD_DATA;
	logic [7:0]            data_byte = 8'h00;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  kind;
	logic [FIELD_BITS-1:0] from_x;
	logic [FIELD_BITS-1:0] from_y;
	logic [FIELD_BITS-1:0] to_x;
	logic [FIELD_BITS-1:0] to_y;

	stream_word_t word_q[$];
	pcsp_result_t seg_expect_q[$];

	// predicted parser and pen state
	tok_state_t            tok_state;
	logic [COORD_BITS-1:0] x_acc;
	logic [COORD_BITS-1:0] y_acc;
	logic [COORD_BITS-1:0] pen_x;
	logic [COORD_BITS-1:0] pen_y;
	logic                  track_open;

	int total_words    = 0;
	int words_accepted = 0;
	int n_eos          = 0;
	int n_segments     = 0;
	int n_track_ends   = 0;
	int n_fail         = 0;
	int n_holds        = 0;
	int drains_done    = 0;
	int idle_cycles    = 0;
	int burst_left     = 0;
	int gap_left       = 0;
	int hold_left      = 0;
	int mode_left      = 0;
	int rx_seen        = 0;
	rx_mode_t rx_mode  = RX_FREE;

	plotter_command_segment_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic char_kept(input logic [7:0] c);
		return (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9) ||
			c == CH_BANG || c == CH_COMMA;
	endfunction

	// decimal accumulate, clamped at the coordinate ceiling
	function automatic logic [COORD_BITS-1:0] sat_digit(input logic [COORD_BITS-1:0] acc,
		input logic [3:0] dv);
		logic [63:0] v;
		v = 64'(acc) * 64'd10 + 64'(dv);
		if (v > 64'(COORD_MAX)) begin
			return COORD_MAX;
		end
		return COORD_BITS'(v);
	endfunction

	function automatic string coord_text();
		string s;
		int    n;
		s = "";
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
		if ($urandom_range(0, 4) == 0) begin
			s = "0";
		end
		repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
		return s;
	endfunction

	task automatic push_word(input logic c, input logic [7:0] d);
		stream_word_t w;
		w = '{1'b0, c, d};
		word_q.insert(word_q.size(), w);
		total_words++;
	endtask

	// queue a text, optionally sprinkling ignored bytes between its characters
	task automatic push_text(input string s, input bit scatter);
		logic [7:0] junk;
		for (int i = 0; i < s.len(); i++) begin
			if (scatter && $urandom_range(0, 19) == 0) begin
				do
					junk = 8'($urandom_range(0, 255));
				while (char_kept(junk) || junk == CH_SEMI);
				push_word(CMD_DATA, junk);
			end
			push_word(CMD_DATA, s[i]);
		end
	endtask

	// stimulus and end of run
	initial begin
		int           pick;
		int           pos;
		int           drains_placed;
		string        tok;
		stream_word_t mark;
		drains_placed = 0;

		// directed: empty track close, leading zeros, skipped byte in a token,
		// end of stream with an open track, malformed token
		push_text("PU;PD1,02;P#U;PD9,9;", 1'b0);
		push_word(CMD_EOS, 8'hA5);
		push_text("PX!;", 1'b0);

		while (total_words < STREAM_WORDS) begin
			if (total_words >= DRAIN_SPACING * (drains_placed + 1)) begin
				mark = '{1'b1, CMD_DATA, 8'h00};
				word_q.insert(word_q.size(), mark);
				drains_placed++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				push_text($sformatf("PD%s,%s;", coord_text(), coord_text()), 1'b1);
			end else if (pick < 53) begin
				push_text($sformatf("PU%s,%s;", coord_text(), coord_text()), 1'b1);
			end else if (pick < 61) begin
				push_text("PU;", 1'b1);
			end else if (pick < 76) begin
				// broken token: cut short or one character swapped
				tok = $sformatf("P%s%s,%s", ($urandom_range(0, 1) != 0) ? "D" : "U",
					coord_text(), coord_text());
				pos = $urandom_range(0, tok.len() - 1);
				if ($urandom_range(0, 1) != 0) begin
					tok = tok.substr(0, pos);
				end else begin
					tok.putc(pos, KEPT_CHARS[$urandom_range(0, KEPT_CHARS.len() - 1)]);
				end
				push_text({tok, ";"}, 1'b1);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) push_word(CMD_DATA, 8'($urandom_range(0, 255)));
			end else begin
				push_word(CMD_EOS, 8'($urandom_range(0, 255)));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (words_accepted < total_words) @(posedge clk);
		while (seg_expect_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("stream of %0d words (%0d end-of-stream) gave %0d segments, %0d track ends",
			words_accepted, n_eos, n_segments, n_track_ends);
		$display("receiver long holds: %0d, sender drain pauses: %0d", n_holds, drains_done);
		if (n_fail == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// sender: bursts and gaps, pausing at drain markers
	always @(posedge clk) begin
		stream_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (word_q.size() != 0 && word_q[0].drain) begin
				in_valid <= 1'b0;
				if (!in_valid && seg_expect_q.size() == 0) begin
					void'(word_q.pop_front());
					drains_done++;
				end
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (word_q.size() != 0) begin
				w = word_q.pop_front();
				in_valid  <= 1'b1;
				cmd       <= w.cmd;
				data_byte <= w.data;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern re-drawn at random, plus long holds
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				rx_seen++;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (out_valid && out_ready && (rx_seen == 8 || rx_seen == 25)) begin
				out_ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				n_holds++;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 100);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_FREE:  out_ready <= 1'b1;
					RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
					default:  out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// predictor: parse each accepted word and queue the result it causes
	always @(posedge clk) begin
		logic         digit;
		logic [3:0]   dval;
		logic         emit;
		pcsp_result_t r;
		if (!arst_n) begin
			tok_state  = TOK_START;
			x_acc      = '0;
			y_acc      = '0;
			pen_x      = '0;
			pen_y      = '0;
			track_open = 1'b0;
		end else if (in_valid && in_ready) begin
			words_accepted++;
			emit  = 1'b0;
			r     = '0;
			digit = data_byte >= CH_0 && data_byte <= CH_9;
			dval  = 4'(data_byte - CH_0);
			if (cmd == CMD_EOS) begin
				// close an open track, then back to origin with a fresh token
				n_eos++;
				if (track_open) begin
					emit   = 1'b1;
					r.kind = KIND_TRACK_END;
				end
				track_open = 1'b0;
				pen_x      = '0;
				pen_y      = '0;
				tok_state  = TOK_START;
				x_acc      = '0;
				y_acc      = '0;
			end else if (data_byte == CH_SEMI) begin
				// token end: act on the three recognized shapes
				if (tok_state == TOK_PU || tok_state == TOK_PU_Y) begin
					if (track_open) begin
						emit       = 1'b1;
						r.kind     = KIND_TRACK_END;
						track_open = 1'b0;
					end
					if (tok_state == TOK_PU_Y) begin
						pen_x = x_acc;
						pen_y = y_acc;
					end
				end else if (tok_state == TOK_PD_Y) begin
					emit       = 1'b1;
					r.kind     = KIND_SEGMENT;
					r.from_x   = pen_x;
					r.from_y   = pen_y;
					r.to_x     = x_acc;
					r.to_y     = y_acc;
					pen_x      = x_acc;
					pen_y      = y_acc;
					track_open = 1'b1;
				end
				tok_state = TOK_START;
				x_acc     = '0;
				y_acc     = '0;
			end else if (char_kept(data_byte)) begin
				case (tok_state)
					TOK_START: tok_state = (data_byte == CH_P) ? TOK_P : TOK_DEAD;
					TOK_P: begin
						tok_state = (data_byte == CH_U) ? TOK_PU :
							(data_byte == CH_D) ? TOK_PD : TOK_DEAD;
					end
					TOK_PU, TOK_PD: begin
						if (digit) begin
							x_acc     = COORD_BITS'(dval);
							tok_state = (tok_state == TOK_PU) ? TOK_PU_X : TOK_PD_X;
						end else begin
							tok_state = TOK_DEAD;
						end
					end
					TOK_PU_X, TOK_PD_X: begin
						if (digit) begin
							x_acc = sat_digit(x_acc, dval);
						end else if (data_byte == CH_COMMA) begin
							tok_state = (tok_state == TOK_PU_X) ? TOK_PU_COMMA : TOK_PD_COMMA;
						end else begin
							tok_state = TOK_DEAD;
						end
					end
					TOK_PU_COMMA, TOK_PD_COMMA: begin
						if (digit) begin
							y_acc     = COORD_BITS'(dval);
							tok_state = (tok_state == TOK_PU_COMMA) ? TOK_PU_Y : TOK_PD_Y;
						end else begin
							tok_state = TOK_DEAD;
						end
					end
					TOK_PU_Y, TOK_PD_Y: begin
						if (digit) begin
							y_acc = sat_digit(y_acc, dval);
						end else begin
							tok_state = TOK_DEAD;
						end
					end
					default: tok_state = TOK_DEAD;
				endcase
			end
			if (emit) begin
				seg_expect_q.insert(seg_expect_q.size(), r);
				if (r.kind == KIND_SEGMENT) begin
					n_segments++;
				end else begin
					n_track_ends++;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		pcsp_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (seg_expect_q.size() == 0) begin
				$error("unexpected result: kind %0d from (%0d,%0d) to (%0d,%0d)",
					kind, from_x, from_y, to_x, to_y);
				n_fail++;
			end else begin
				want = seg_expect_q.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					n_fail++;
				end
				if (from_x !== want.from_x) begin
					$error("from_x: expected %0d, got %0d", want.from_x, from_x);
					n_fail++;
				end
				if (from_y !== want.from_y) begin
					$error("from_y: expected %0d, got %0d", want.from_y, from_y);
					n_fail++;
				end
				if (to_x !== want.to_x) begin
					$error("to_x: expected %0d, got %0d", want.to_x, to_x);
					n_fail++;
				end
				if (to_y !== want.to_y) begin
					$error("to_y: expected %0d, got %0d", want.to_y, to_y);
					n_fail++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results outstanding",
				idle_cycles, seg_expect_q.size());
			$display("FAIL");
			$finish;
		end
	end

endmodule
